FILE: rtl/kdrl_pkg.sv
// kdrl_pkg: types, codes and helpers shared by the key qualifier block
// no dependencies; used by kdrl_key and key_debounce_repeat_longpress_top

package kdrl_pkg;

  // number of key slots on the ports (bits of a field per key)
  localparam int MAX_KEYS = 6;

  // request function codes
  localparam logic [1:0] FUNC_TICK        = 2'd0;
  localparam logic [1:0] FUNC_CLR_NOTIFY  = 2'd1;
  localparam logic [1:0] FUNC_CLR_TRIPLE  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_CHECK_PERIOD   = 3'd0;
  localparam logic [2:0] REG_LEVEL_THRESH   = 3'd1;
  localparam logic [2:0] REG_FIRST_GAP      = 3'd2;
  localparam logic [2:0] REG_SINGLE_LIMIT   = 3'd3;
  localparam logic [2:0] REG_CONT_GAP       = 3'd4;
  localparam logic [2:0] REG_LONG_REPEATS   = 3'd5;

  // notify codes
  localparam logic [2:0] NOTIFY_NONE     = 3'd0;
  localparam logic [2:0] NOTIFY_PRESS    = 3'd1;
  localparam logic [2:0] NOTIFY_REPEAT   = 3'd2;
  localparam logic [2:0] NOTIFY_LONG     = 3'd3;
  localparam logic [2:0] NOTIFY_RELEASED = 3'd4;

  // release tracking
  localparam logic [4:0] RELEASE_TIMEOUT_LIMIT = 5'd30;
  localparam logic [2:0] TRIPLE_COUNT          = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DEBOUNCE = 3'd1,
    ST_SINGLE   = 3'd2,
    ST_CONT     = 3'd3,
    ST_RELEASE  = 3'd4
  } press_state_t;

  typedef enum logic [1:0] {
    LVL_HIGH    = 2'd0,
    LVL_LOW     = 2'd1,
    LVL_INVALID = 2'd2
  } level_t;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] key_levels;
    logic [2:0] key_index;
  } in_t;

  typedef struct packed {
    logic        check_done;
    logic [17:0] notify_codes;
    logic [5:0]  pressed_flags;
    logic [5:0]  triple_flags;
  } out_t;

  typedef struct packed {
    logic [7:0] check_period;
    logic [7:0] level_threshold;
    logic [7:0] first_repeat_gap;
    logic [7:0] single_repeat_limit;
    logic [7:0] continuous_gap;
    logic [7:0] long_press_repeats;
  } cfg_t;

  // per-key command for the current request
  typedef struct packed {
    logic tick;
    logic check;
    logic level;
    logic clr_notify;
    logic clr_triple;
  } key_cmd_t;

  // per-key status after the current request
  typedef struct packed {
    logic [2:0] notify;
    logic       pressed;
    logic       triple;
  } key_stat_t;

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

FILE: rtl/key_debounce_repeat_longpress_top.sv
// Key qualifier for up to six keys: debounce, auto-repeat, long press and
// triple release. Takes one request per clock unless out_stall holds a result;
// each request passes an input register and then updates every key in parallel
// and loads the result register, from which its result is offered.
// The rate is one request per cycle while the receiver does not stall.
// The result register lets a new request in while an earlier result waits.
// Ticks run the state machine check every check_period ticks; notify codes
// stay until cleared by a clear-notify request.
// depends on kdrl_pkg and kdrl_key

module key_debounce_repeat_longpress_top #(
  parameter int NUM_KEYS = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  kdrl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output kdrl_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [7:0]     cfg_data
);

  kdrl_pkg::cfg_t      cfg;
  logic                s1_valid;
  kdrl_pkg::in_t       s1_data;
  logic                s1_adv;
  logic                process;
  logic                tick;
  logic                check;
  logic [7:0]          tick_count, tick_count_next;
  logic [7:0]          tick_inc;
  kdrl_pkg::key_stat_t stat [kdrl_pkg::MAX_KEYS];
  kdrl_pkg::out_t      result;

  // handshake: input register advances whenever the result register is free
  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign process  = s1_valid && s1_adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_period        <= 8'd3;
      cfg.level_threshold     <= 8'd1;
      cfg.first_repeat_gap    <= 8'd10;
      cfg.single_repeat_limit <= 8'd2;
      cfg.continuous_gap      <= 8'd3;
      cfg.long_press_repeats  <= 8'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kdrl_pkg::REG_CHECK_PERIOD: cfg.check_period        <= cfg_data;
        kdrl_pkg::REG_LEVEL_THRESH: cfg.level_threshold     <= cfg_data;
        kdrl_pkg::REG_FIRST_GAP:    cfg.first_repeat_gap    <= cfg_data;
        kdrl_pkg::REG_SINGLE_LIMIT: cfg.single_repeat_limit <= cfg_data;
        kdrl_pkg::REG_CONT_GAP:     cfg.continuous_gap      <= cfg_data;
        kdrl_pkg::REG_LONG_REPEATS: cfg.long_press_repeats  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  // tick counter and check decision
  always_comb begin
    tick     = process && (s1_data.func == kdrl_pkg::FUNC_TICK);
    tick_inc = kdrl_pkg::sat_inc8(tick_count);
    check    = tick && (tick_inc >= cfg.check_period);
    if (check) begin
      tick_count_next = 8'd0;
    end else if (tick) begin
      tick_count_next = tick_inc;
    end else begin
      tick_count_next = tick_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= 8'd0;
    end else begin
      tick_count <= tick_count_next;
    end
  end

  // per-key units; unused key slots report zero
  for (genvar k = 0; k < kdrl_pkg::MAX_KEYS; k++) begin : g_key
    if (k < NUM_KEYS) begin : g_used
      kdrl_pkg::key_cmd_t cmd;

      always_comb begin
        cmd.tick       = tick;
        cmd.check      = check;
        cmd.level      = s1_data.key_levels[k];
        cmd.clr_notify = process && (s1_data.func == kdrl_pkg::FUNC_CLR_NOTIFY)
                         && (s1_data.key_index == 3'(k));
        cmd.clr_triple = process && (s1_data.func == kdrl_pkg::FUNC_CLR_TRIPLE)
                         && (s1_data.key_index == 3'(k));
      end

      kdrl_key u_key (
        .clk  (clk),
        .rst  (rst),
        .cfg  (cfg),
        .cmd  (cmd),
        .stat (stat[k])
      );
    end else begin : g_unused
      assign stat[k] = '0;
    end
  end

  // result assembly
  always_comb begin
    result.check_done = check;
    for (int k = 0; k < kdrl_pkg::MAX_KEYS; k++) begin
      result.notify_codes[3*k +: 3] = stat[k].notify;
      result.pressed_flags[k]       = stat[k].pressed;
      result.triple_flags[k]        = stat[k].triple;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_data <= result;
    end
  end

endmodule

FILE: rtl/kdrl_key.sv
// kdrl_key: sample counters, press state machine and release tracking of one key
// depends on kdrl_pkg

module kdrl_key (
  input  logic                clk,
  input  logic                rst,
  input  kdrl_pkg::cfg_t      cfg,
  input  kdrl_pkg::key_cmd_t  cmd,
  output kdrl_pkg::key_stat_t stat
);

  localparam logic [4:0] RELEASE_TIMEOUT_LIMIT_L = kdrl_pkg::RELEASE_TIMEOUT_LIMIT;

  kdrl_pkg::press_state_t state, state_next;
  logic [7:0] high_samples, high_samples_next;
  logic [7:0] low_samples, low_samples_next;
  logic [7:0] gap_count, gap_count_next;
  logic [7:0] single_count, single_count_next;
  logic [7:0] long_count, long_count_next;
  logic [2:0] notify_latch, notify_latch_next;
  logic [1:0] release_count, release_count_next;
  logic       triple_flag, triple_flag_next;
  logic [4:0] release_timeout, release_timeout_next;

  logic [7:0]       high_inc, low_inc;
  kdrl_pkg::level_t lvl;
  logic             go_cont;
  logic [7:0]       gap_tmp, single_tmp, long_tmp;
  logic [4:0]       rt_tmp;
  logic [2:0]       rc_tmp;

  // sample counting and level classification
  always_comb begin
    high_inc = (cmd.tick && cmd.level) ? kdrl_pkg::sat_inc8(high_samples) : high_samples;
    low_inc  = (cmd.tick && !cmd.level) ? kdrl_pkg::sat_inc8(low_samples) : low_samples;
    if (high_inc > cfg.level_threshold) begin
      lvl = kdrl_pkg::LVL_HIGH;
    end else if (low_inc > cfg.level_threshold) begin
      lvl = kdrl_pkg::LVL_LOW;
    end else begin
      lvl = kdrl_pkg::LVL_INVALID;
    end
    high_samples_next = cmd.check ? 8'd0 : high_inc;
    low_samples_next  = cmd.check ? 8'd0 : low_inc;
  end

  // repeat, long press and notify counters
  always_comb begin
    gap_count_next    = gap_count;
    single_count_next = single_count;
    long_count_next   = long_count;
    notify_latch_next = notify_latch;
    go_cont           = 1'b0;
    gap_tmp           = kdrl_pkg::sat_inc8(gap_count);
    single_tmp        = single_count;
    long_tmp          = long_count + 8'd1;
    if (cmd.check) begin
      case (state)
        kdrl_pkg::ST_DEBOUNCE: begin
          if (lvl == kdrl_pkg::LVL_LOW) begin
            notify_latch_next = kdrl_pkg::NOTIFY_PRESS;
            gap_count_next    = 8'd0;
          end
        end
        kdrl_pkg::ST_SINGLE: begin
          if (lvl == kdrl_pkg::LVL_LOW) begin
            gap_count_next = gap_tmp;
            if (gap_tmp > cfg.first_repeat_gap) begin
              notify_latch_next = kdrl_pkg::NOTIFY_REPEAT;
              gap_count_next    = 8'd0;
              single_tmp        = kdrl_pkg::sat_inc8(single_count);
            end
            single_count_next = single_tmp;
            if (single_tmp > cfg.single_repeat_limit) begin
              go_cont           = 1'b1;
              single_count_next = 8'd0;
              long_count_next   = 8'd0;
            end
          end
        end
        kdrl_pkg::ST_CONT: begin
          if (lvl == kdrl_pkg::LVL_LOW) begin
            gap_count_next = gap_tmp;
            if (gap_tmp >= cfg.continuous_gap) begin
              notify_latch_next = kdrl_pkg::NOTIFY_REPEAT;
              gap_count_next    = 8'd0;
              long_count_next   = long_tmp;
              if (long_tmp == cfg.long_press_repeats) begin
                notify_latch_next = kdrl_pkg::NOTIFY_LONG;
                long_count_next   = 8'd0;
              end
            end
          end
        end
        kdrl_pkg::ST_RELEASE: begin
          if (lvl == kdrl_pkg::LVL_HIGH) begin
            notify_latch_next = kdrl_pkg::NOTIFY_RELEASED;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.clr_notify) begin
      notify_latch_next = kdrl_pkg::NOTIFY_NONE;
    end
  end

  // press state machine: next state
  always_comb begin
    state_next = state;
    if (cmd.check) begin
      unique case (state)
        kdrl_pkg::ST_IDLE: begin
          if (lvl == kdrl_pkg::LVL_LOW) state_next = kdrl_pkg::ST_DEBOUNCE;
        end
        kdrl_pkg::ST_DEBOUNCE: begin
          if (lvl == kdrl_pkg::LVL_HIGH) begin
            state_next = kdrl_pkg::ST_RELEASE;
          end else if (lvl == kdrl_pkg::LVL_LOW) begin
            state_next = kdrl_pkg::ST_SINGLE;
          end
        end
        kdrl_pkg::ST_SINGLE: begin
          if (lvl != kdrl_pkg::LVL_LOW) begin
            state_next = kdrl_pkg::ST_DEBOUNCE;
          end else if (go_cont) begin
            state_next = kdrl_pkg::ST_CONT;
          end
        end
        kdrl_pkg::ST_CONT: begin
          if (lvl != kdrl_pkg::LVL_LOW) state_next = kdrl_pkg::ST_DEBOUNCE;
        end
        kdrl_pkg::ST_RELEASE: begin
          state_next = (lvl == kdrl_pkg::LVL_HIGH) ? kdrl_pkg::ST_IDLE
                                                   : kdrl_pkg::ST_DEBOUNCE;
        end
        default: state_next = kdrl_pkg::ST_IDLE;
      endcase
    end
  end

  // release counting with timeout, triple flag
  always_comb begin
    release_timeout_next = release_timeout;
    release_count_next   = release_count;
    triple_flag_next     = triple_flag;
    rt_tmp               = release_timeout + 5'd1;
    rc_tmp               = 3'd0;
    if (cmd.check) begin
      release_timeout_next = rt_tmp;
      if (rt_tmp > RELEASE_TIMEOUT_LIMIT_L) begin
        release_timeout_next = 5'd0;
        release_count_next   = 2'd0;
        triple_flag_next     = 1'b0;
      end
      if (state_next == kdrl_pkg::ST_RELEASE) begin
        release_timeout_next = 5'd0;
        rc_tmp               = {1'b0, release_count_next} + 3'd1;
        if (rc_tmp >= kdrl_pkg::TRIPLE_COUNT) begin
          triple_flag_next   = 1'b1;
          release_count_next = kdrl_pkg::TRIPLE_COUNT[1:0];
        end else begin
          release_count_next = rc_tmp[1:0];
        end
      end
    end else if (cmd.clr_triple) begin
      release_count_next = 2'd0;
      triple_flag_next   = 1'b0;
    end
  end

  // press state machine: status outputs
  always_comb begin
    stat.notify  = notify_latch_next;
    stat.pressed = (state_next == kdrl_pkg::ST_SINGLE) || (state_next == kdrl_pkg::ST_CONT);
    stat.triple  = triple_flag_next;
  end

  // key state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= kdrl_pkg::ST_IDLE;
      high_samples    <= 8'd0;
      low_samples     <= 8'd0;
      gap_count       <= 8'd0;
      single_count    <= 8'd0;
      long_count      <= 8'd0;
      notify_latch    <= kdrl_pkg::NOTIFY_NONE;
      release_count   <= 2'd0;
      triple_flag     <= 1'b0;
      release_timeout <= 5'd0;
    end else begin
      state           <= state_next;
      high_samples    <= high_samples_next;
      low_samples     <= low_samples_next;
      gap_count       <= gap_count_next;
      single_count    <= single_count_next;
      long_count      <= long_count_next;
      notify_latch    <= notify_latch_next;
      release_count   <= release_count_next;
      triple_flag     <= triple_flag_next;
      release_timeout <= release_timeout_next;
    end
  end

endmodule

FILE: bench/key_debounce_repeat_longpress_top_tb.sv
// key_debounce_repeat_longpress_top_tb: self-checking bench for the key qualifier,
// predicting every result from its own model of the per-key state machines
// depends on kdrl_pkg and key_debounce_repeat_longpress_top
`timescale 1ns / 100ps

module key_debounce_repeat_longpress_top_tb;

  // unused request function code
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  // cycles without any request or result moving before the run is abandoned
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int NKEYS = kdrl_pkg::MAX_KEYS;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  kdrl_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kdrl_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  key_debounce_repeat_longpress_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // model of the block: settings and per-key state
  kdrl_pkg::cfg_t model_cfg;
  logic [7:0] tick_cnt;
  kdrl_pkg::press_state_t press_st[NKEYS];
  logic [7:0] high_cnt[NKEYS];
  logic [7:0] low_cnt[NKEYS];
  logic [7:0] gap_cnt[NKEYS];
  logic [7:0] single_cnt[NKEYS];
  logic [7:0] long_cnt[NKEYS];
  logic [2:0] notify[NKEYS];
  logic [1:0] rel_cnt[NKEYS];
  logic triple[NKEYS];
  logic [4:0] rel_timeout[NKEYS];

  kdrl_pkg::out_t expected_status[$];
  int failures = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  logic [5:0] held_levels = 6'h3F;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] bump8(logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // one check of one key: classify the samples, step the machine, track releases
  function automatic void check_one_key(int k);
    kdrl_pkg::level_t lvl;
    logic [2:0] rel_next;
    if (high_cnt[k] > model_cfg.level_threshold) lvl = kdrl_pkg::LVL_HIGH;
    else if (low_cnt[k] > model_cfg.level_threshold) lvl = kdrl_pkg::LVL_LOW;
    else lvl = kdrl_pkg::LVL_INVALID;
    high_cnt[k] = '0;
    low_cnt[k] = '0;
    case (press_st[k])
      kdrl_pkg::ST_IDLE: begin
        if (lvl == kdrl_pkg::LVL_LOW) press_st[k] = kdrl_pkg::ST_DEBOUNCE;
      end
      kdrl_pkg::ST_DEBOUNCE: begin
        if (lvl == kdrl_pkg::LVL_HIGH) begin
          press_st[k] = kdrl_pkg::ST_RELEASE;
        end else if (lvl == kdrl_pkg::LVL_LOW) begin
          press_st[k] = kdrl_pkg::ST_SINGLE;
          notify[k] = kdrl_pkg::NOTIFY_PRESS;
          gap_cnt[k] = '0;
        end
      end
      kdrl_pkg::ST_SINGLE: begin
        if (lvl == kdrl_pkg::LVL_LOW) begin
          gap_cnt[k] = bump8(gap_cnt[k]);
          if (gap_cnt[k] > model_cfg.first_repeat_gap) begin
            notify[k] = kdrl_pkg::NOTIFY_REPEAT;
            gap_cnt[k] = '0;
            single_cnt[k] = bump8(single_cnt[k]);
          end
          if (single_cnt[k] > model_cfg.single_repeat_limit) begin
            press_st[k] = kdrl_pkg::ST_CONT;
            single_cnt[k] = '0;
            long_cnt[k] = '0;
          end
        end else begin
          press_st[k] = kdrl_pkg::ST_DEBOUNCE;
        end
      end
      kdrl_pkg::ST_CONT: begin
        if (lvl == kdrl_pkg::LVL_LOW) begin
          gap_cnt[k] = bump8(gap_cnt[k]);
          if (gap_cnt[k] >= model_cfg.continuous_gap) begin
            notify[k] = kdrl_pkg::NOTIFY_REPEAT;
            gap_cnt[k] = '0;
            long_cnt[k] = long_cnt[k] + 8'd1;
            if (long_cnt[k] == model_cfg.long_press_repeats) begin
              notify[k] = kdrl_pkg::NOTIFY_LONG;
              long_cnt[k] = '0;
            end
          end
        end else begin
          press_st[k] = kdrl_pkg::ST_DEBOUNCE;
        end
      end
      kdrl_pkg::ST_RELEASE: begin
        if (lvl == kdrl_pkg::LVL_HIGH) begin
          press_st[k] = kdrl_pkg::ST_IDLE;
          notify[k] = kdrl_pkg::NOTIFY_RELEASED;
        end else begin
          press_st[k] = kdrl_pkg::ST_DEBOUNCE;
        end
      end
      default: press_st[k] = kdrl_pkg::ST_IDLE;
    endcase
    // release window and triple detection
    rel_timeout[k] = rel_timeout[k] + 5'd1;
    if (rel_timeout[k] > kdrl_pkg::RELEASE_TIMEOUT_LIMIT) begin
      rel_timeout[k] = '0;
      rel_cnt[k] = '0;
      triple[k] = 1'b0;
    end
    if (press_st[k] == kdrl_pkg::ST_RELEASE) begin
      rel_timeout[k] = '0;
      rel_next = {1'b0, rel_cnt[k]} + 3'd1;
      if (rel_next >= kdrl_pkg::TRIPLE_COUNT) begin
        triple[k] = 1'b1;
        rel_next = kdrl_pkg::TRIPLE_COUNT;
      end
      rel_cnt[k] = rel_next[1:0];
    end
  endfunction

  // apply one request to the model and return the status it should report
  function automatic kdrl_pkg::out_t key_status_after(kdrl_pkg::in_t req);
    kdrl_pkg::out_t res;
    res = '0;
    case (req.func)
      kdrl_pkg::FUNC_TICK: begin
        tick_cnt = bump8(tick_cnt);
        for (int k = 0; k < NKEYS; k++) begin
          if (req.key_levels[k]) high_cnt[k] = bump8(high_cnt[k]);
          else low_cnt[k] = bump8(low_cnt[k]);
        end
        if (tick_cnt >= model_cfg.check_period) begin
          for (int k = 0; k < NKEYS; k++) check_one_key(k);
          tick_cnt = '0;
          res.check_done = 1'b1;
        end
      end
      kdrl_pkg::FUNC_CLR_NOTIFY: begin
        if (req.key_index < NKEYS) notify[req.key_index] = kdrl_pkg::NOTIFY_NONE;
      end
      kdrl_pkg::FUNC_CLR_TRIPLE: begin
        if (req.key_index < NKEYS) begin
          rel_cnt[req.key_index] = '0;
          triple[req.key_index] = 1'b0;
        end
      end
      default: ;
    endcase
    for (int k = 0; k < NKEYS; k++) begin
      res.notify_codes[3*k +: 3] = notify[k];
      res.pressed_flags[k] = (press_st[k] == kdrl_pkg::ST_SINGLE)
                             || (press_st[k] == kdrl_pkg::ST_CONT);
      res.triple_flags[k] = triple[k];
    end
    return res;
  endfunction

  function automatic kdrl_pkg::in_t make_req(logic [1:0] func, logic [5:0] levels,
                                             logic [2:0] index);
    kdrl_pkg::in_t req;
    req.func = func;
    req.key_levels = levels;
    req.key_index = index;
    return req;
  endfunction

  // offer one request, idling first at the set rate, and predict it once taken
  task automatic send_request(kdrl_pkg::in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_status.push_back(key_status_after(req));
  endtask

  // stop offering and let every outstanding result come back
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all six settings while the block is idle
  task automatic load_settings(kdrl_pkg::cfg_t c);
    logic [2:0] idx_list[6];
    logic [7:0] val_list[6];
    idx_list = '{kdrl_pkg::REG_CHECK_PERIOD, kdrl_pkg::REG_LEVEL_THRESH,
                 kdrl_pkg::REG_FIRST_GAP, kdrl_pkg::REG_SINGLE_LIMIT,
                 kdrl_pkg::REG_CONT_GAP, kdrl_pkg::REG_LONG_REPEATS};
    val_list = '{c.check_period, c.level_threshold, c.first_repeat_gap,
                 c.single_repeat_limit, c.continuous_gap, c.long_press_repeats};
    finish_phase();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data <= val_list[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    model_cfg = c;
    @(posedge clk);
  endtask

  function automatic kdrl_pkg::cfg_t random_small_settings();
    kdrl_pkg::cfg_t c;
    c.check_period = 8'($urandom_range(1, 4));
    c.level_threshold = 8'($urandom_range(0, c.check_period - 8'd1));
    c.first_repeat_gap = 8'($urandom_range(0, 4));
    c.single_repeat_limit = 8'($urandom_range(0, 3));
    c.continuous_gap = 8'($urandom_range(1, 4));
    c.long_press_repeats = 8'($urandom_range(1, 6));
    return c;
  endfunction

  // held key levels with occasional bounce, mixed with clear requests and noise
  task automatic send_key_traffic(int count, int flip_pct);
    kdrl_pkg::in_t req;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      req.key_index = 3'($urandom_range(7));
      req.key_levels = 6'($urandom);
      if (r < 80) begin
        for (int k = 0; k < NKEYS; k++)
          if ($urandom_range(99) < flip_pct) held_levels[k] = ~held_levels[k];
        req.func = kdrl_pkg::FUNC_TICK;
        req.key_levels = held_levels;
        // contact bounce on one key
        if ($urandom_range(99) < 8) req.key_levels[$urandom_range(NKEYS - 1)] ^= 1'b1;
      end else if (r < 90) begin
        req.func = kdrl_pkg::FUNC_CLR_NOTIFY;
      end else if (r < 97) begin
        req.func = kdrl_pkg::FUNC_CLR_TRIPLE;
      end else begin
        req.func = FUNC_SPARE;
      end
      send_request(req);
    end
  endtask

  // reset values and fast settings, walking one press through every state
  task automatic test_directed();
    kdrl_pkg::cfg_t fast;
    fast = '{check_period: 8'd1, level_threshold: 8'd0, first_repeat_gap: 8'd0,
             single_repeat_limit: 8'd0, continuous_gap: 8'd1, long_press_repeats: 8'd1};
    send_request(make_req(FUNC_SPARE, 6'h3F, 3'd7));
    send_request(make_req(kdrl_pkg::FUNC_CLR_NOTIFY, 6'h3F, 3'd7));
    send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h00, 3'd0));
    send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h3F, 3'd0));
    send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h00, 3'd0));
    load_settings(fast);
    // press, repeat, continuous and long press on all keys
    repeat (4) send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h00, 3'd0));
    send_request(make_req(kdrl_pkg::FUNC_CLR_NOTIFY, 6'h00, 3'd0));
    send_request(make_req(kdrl_pkg::FUNC_CLR_NOTIFY, 6'h00, 3'd5));
    send_request(make_req(kdrl_pkg::FUNC_CLR_NOTIFY, 6'h3F, 3'd6));
    // three quick releases for the triple flag, then a clean release
    send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h3F, 3'd0));
    send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h3F, 3'd0));
    send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h00, 3'd0));
    send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h3F, 3'd0));
    send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h00, 3'd0));
    send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h3F, 3'd0));
    send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h3F, 3'd0));
    send_request(make_req(kdrl_pkg::FUNC_CLR_TRIPLE, 6'h00, 3'd2));
    send_request(make_req(kdrl_pkg::FUNC_CLR_TRIPLE, 6'h3F, 3'd6));
    send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h2A, 3'd0));
    send_request(make_req(kdrl_pkg::FUNC_TICK, 6'h15, 3'd0));
  endtask

  task automatic test_minimum_settings();
    load_settings('{check_period: 8'd1, level_threshold: 8'd0, first_repeat_gap: 8'd0,
                    single_repeat_limit: 8'd0, continuous_gap: 8'd1,
                    long_press_repeats: 8'd1});
    send_idle_pct = 0;
    stall_pct = 0;
    send_key_traffic(120, 10);
  endtask

  task automatic test_sender_gaps();
    load_settings(random_small_settings());
    send_idle_pct = 73;
    stall_pct = 0;
    send_key_traffic(120, 8);
  endtask

  // long receiver hold-off while requests keep coming, then random stalls
  task automatic test_receiver_backpressure();
    load_settings(random_small_settings());
    send_idle_pct = 0;
    stall_pct = 73;
    hold_request = HOLD_CYCLES;
    send_key_traffic(120, 8);
  endtask

  task automatic test_mixed_idling();
    load_settings(random_small_settings());
    send_idle_pct = 30;
    stall_pct = 30;
    send_key_traffic(120, 12);
  endtask

  task automatic test_maximum_settings();
    load_settings('{check_period: 8'd255, level_threshold: 8'd255, first_repeat_gap: 8'd255,
                    single_repeat_limit: 8'd255, continuous_gap: 8'd255,
                    long_press_repeats: 8'd255});
    send_idle_pct = 0;
    stall_pct = 0;
    send_key_traffic(300, 1);
  endtask

  // receiver: random stalls, or a held stretch when one is asked for
  always @(posedge clk) begin
    int hold_left;
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare each result against the oldest prediction
  always @(posedge clk) begin
    kdrl_pkg::out_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        $error("unexpected result %h", out_data);
        failures++;
      end else begin
        exp_res = expected_status.pop_front();
        if (out_data.check_done !== exp_res.check_done) begin
          $error("check_done: expected %0h, got %0h", exp_res.check_done, out_data.check_done);
          failures++;
        end
        if (out_data.notify_codes !== exp_res.notify_codes) begin
          $error("notify_codes: expected %h, got %h",
                 exp_res.notify_codes, out_data.notify_codes);
          failures++;
        end
        if (out_data.pressed_flags !== exp_res.pressed_flags) begin
          $error("pressed_flags: expected %h, got %h",
                 exp_res.pressed_flags, out_data.pressed_flags);
          failures++;
        end
        if (out_data.triple_flags !== exp_res.triple_flags) begin
          $error("triple_flags: expected %h, got %h",
                 exp_res.triple_flags, out_data.triple_flags);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // test sequence
  initial begin
    model_cfg = '{check_period: 8'd3, level_threshold: 8'd1, first_repeat_gap: 8'd10,
                  single_repeat_limit: 8'd2, continuous_gap: 8'd3,
                  long_press_repeats: 8'd20};
    tick_cnt = '0;
    for (int k = 0; k < NKEYS; k++) begin
      press_st[k] = kdrl_pkg::ST_IDLE;
      high_cnt[k] = '0;
      low_cnt[k] = '0;
      gap_cnt[k] = '0;
      single_cnt[k] = '0;
      long_cnt[k] = '0;
      notify[k] = kdrl_pkg::NOTIFY_NONE;
      rel_cnt[k] = '0;
      triple[k] = 1'b0;
      rel_timeout[k] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_minimum_settings();
    test_sender_gaps();
    test_receiver_backpressure();
    test_mixed_idling();
    test_maximum_settings();
    finish_phase();
    repeat (8) @(posedge clk);
    if (failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
